>>> rtl/dtu_pkg.sv
// ----------------------------------------------------------------------------
// dtu_pkg
// Types, constants and tables shared by the date to unix seconds pipeline.
// ----------------------------------------------------------------------------
package dtu_pkg;

  localparam int unsigned YEAR_W   = 12;
  localparam int unsigned DAYS_W   = 18;  // day count since the epoch, plus one
  localparam int unsigned SECS_W   = 34;
  localparam int unsigned YDAY_W   = 9;
  localparam int unsigned WDAY_W   = 3;

  localparam logic [YEAR_W-1:0] YEAR_LOW  = 12'd1970;
  localparam logic [YEAR_W-1:0] YEAR_HIGH = 12'd2399;
  localparam logic [YEAR_W-1:0] YEAR_BASE = 12'd1900;

  // days before each month in a common year
  localparam logic [8:0] DAYS_BEFORE_MONTH [12] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } in_t;

  typedef struct packed {
    logic [SECS_W-1:0] epoch_seconds;
    logic [WDAY_W-1:0] weekday;
    logic [YDAY_W-1:0] day_of_year;
  } out_t;

endpackage

>>> rtl/date_to_unix_seconds.sv
// ----------------------------------------------------------------------------
// date_to_unix_seconds
// Gregorian UTC date and time to seconds since 1970, weekday and day of year.
// ----------------------------------------------------------------------------
// Five-stage pipeline that takes one date per cycle and returns each result
// in order. Stage one clamps the year to 1970..2399 and the month to 1..12
// (others count as January) and looks up the month table, stage two forms
// the day count with the leap-day terms, stage three finds the weekday and
// scales to hours, and stages four and five scale by sixty to minutes and
// seconds. Day, hour, minute and second add in linearly; seconds wrap modulo
// 2^34. Backpressure on the output stalls the stages behind it without loss,
// and the input stays ready while any stage has room.
module date_to_unix_seconds (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  dtu_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output dtu_pkg::out_t  out_data
);
  import dtu_pkg::*;

  localparam int unsigned NSTG = 5;

  logic [NSTG-1:0] v_r;
  logic [NSTG:0]   adv;

  // a stage takes new data when it is empty or its content moves on
  always_comb begin
    adv[NSTG] = out_ready;
    for (int k = NSTG - 1; k >= 0; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = v_r[NSTG-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (adv[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // ---------------- stage 1: clamp and table
  logic [YEAR_W-1:0] year_c;
  logic [3:0]        mi;
  logic [8:0]        ty;
  logic              leap;
  logic [8:0]        dbm;

  logic [8:0] yoff_nxt, ly_nxt, yday_nxt;

  logic [8:0]        yoff_r, ly_r, dbm1_r, yday1_r;
  logic [4:0]        day1_r, hour1_r;
  logic [5:0]        min1_r, sec1_r;

  always_comb begin
    if (in_data.year < YEAR_LOW) begin
      year_c = YEAR_LOW;
    end else if (in_data.year > YEAR_HIGH) begin
      year_c = YEAR_HIGH;
    end else begin
      year_c = in_data.year;
    end
    if (in_data.month == 4'd0 || in_data.month > 4'd12) begin
      mi = 4'd0;
    end else begin
      mi = in_data.month - 4'd1;
    end
    ty   = 9'(year_c - YEAR_BASE);
    leap = (year_c[1:0] == 2'b00) && (year_c != 12'd2100) &&
           (year_c != 12'd2200) && (year_c != 12'd2300);
    dbm  = DAYS_BEFORE_MONTH[mi];
    yoff_nxt = ty - 9'd70;
    // the current year's leap day only counts from March on
    ly_nxt   = (mi <= 4'd1) ? ty - 9'd1 : ty;
    yday_nxt = dbm + {4'd0, in_data.day} + {8'd0, (mi >= 4'd2) && leap} - 9'd1;
  end

  always_ff @(posedge clk) begin
    if (adv[0] && in_valid) begin
      yoff_r  <= yoff_nxt;
      ly_r    <= ly_nxt;
      dbm1_r  <= dbm;
      yday1_r <= yday_nxt;
      day1_r  <= in_data.day;
      hour1_r <= in_data.hour;
      min1_r  <= in_data.minute;
      sec1_r  <= in_data.second;
    end
  end

  // ---------------- stage 2: day count
  logic [DAYS_W-1:0] dplus_nxt;
  logic [2:0]        cent;
  logic [8:0]        lq;

  logic [DAYS_W-1:0] dplus_r;
  logic [8:0]        yday2_r;
  logic [4:0]        hour2_r;
  logic [5:0]        min2_r, sec2_r;

  always_comb begin
    cent = 3'({2'd0, ly_r >= 9'd100} + {2'd0, ly_r >= 9'd200} +
              {2'd0, ly_r >= 9'd300} + {2'd0, ly_r >= 9'd400});
    lq   = (ly_r - 9'd68) >> 2;
    dplus_nxt = DAYS_W'({9'd0, yoff_r} * 18'd365) + DAYS_W'(dbm1_r) + DAYS_W'(lq)
              - DAYS_W'(cent) + DAYS_W'(ly_r >= 9'd100) + DAYS_W'(day1_r);
  end

  always_ff @(posedge clk) begin
    if (adv[1] && v_r[0]) begin
      dplus_r <= dplus_nxt;
      yday2_r <= yday1_r;
      hour2_r <= hour1_r;
      min2_r  <= min1_r;
      sec2_r  <= sec1_r;
    end
  end

  // ---------------- stage 3: weekday and hours
  logic [WDAY_W-1:0] wday;
  logic [SECS_W-1:0] dp_w, hours_nxt;

  logic [SECS_W-1:0] hours_r;
  logic [WDAY_W-1:0] wday3_r;
  logic [8:0]        yday3_r;
  logic [5:0]        min3_r, sec3_r;

  dtu_mod7 u_mod7 (
    .x   (dplus_r + DAYS_W'(3)),
    .rem (wday)
  );

  always_comb begin
    dp_w      = SECS_W'(dplus_r);
    hours_nxt = (dp_w << 4) + (dp_w << 3) - SECS_W'(24) + SECS_W'(hour2_r);
  end

  always_ff @(posedge clk) begin
    if (adv[2] && v_r[1]) begin
      hours_r <= hours_nxt;
      wday3_r <= wday;
      yday3_r <= yday2_r;
      min3_r  <= min2_r;
      sec3_r  <= sec2_r;
    end
  end

  // ---------------- stage 4: minutes
  logic [SECS_W-1:0] mins_r;
  logic [WDAY_W-1:0] wday4_r;
  logic [8:0]        yday4_r;
  logic [5:0]        sec4_r;

  always_ff @(posedge clk) begin
    if (adv[3] && v_r[2]) begin
      mins_r  <= (hours_r << 6) - (hours_r << 2) + SECS_W'(min3_r);
      wday4_r <= wday3_r;
      yday4_r <= yday3_r;
      sec4_r  <= sec3_r;
    end
  end

  // ---------------- stage 5: seconds, output register
  out_t out_r;

  always_ff @(posedge clk) begin
    if (adv[4] && v_r[3]) begin
      out_r.epoch_seconds <= (mins_r << 6) - (mins_r << 2) + SECS_W'(sec4_r);
      out_r.weekday       <= wday4_r;
      out_r.day_of_year   <= yday4_r;
    end
  end

  assign out_data = out_r;

`ifndef ASSERT_OFF
  a_in_fills_stage1: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> v_r[0])
    else $error("accepted input did not enter stage one");

  a_stall_holds_stage2: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[1] && !adv[2] |=> v_r[1] && $stable(dplus_r))
    else $error("stalled stage two lost or changed its item");

  a_weekday_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[2] |-> wday3_r <= 3'd6)
    else $error("weekday out of range");

  a_ready_when_room: assert property (@(posedge clk) disable iff (!rst_n)
    !v_r[0] |-> in_ready)
    else $error("input not ready while first stage empty");
`endif

endmodule

>>> rtl/dtu_mod7.sv
// ----------------------------------------------------------------------------
// dtu_mod7
// Remainder of a day count by seven, via reciprocal multiply and one fixup.
// ----------------------------------------------------------------------------
module dtu_mod7 (
  input  logic [dtu_pkg::DAYS_W-1:0] x,
  output logic [dtu_pkg::WDAY_W-1:0] rem
);
  import dtu_pkg::*;

  // 37449 / 2^18 sits just below 1/7, so the quotient is exact or one low
  localparam logic [15:0] RECIP = 16'd37449;

  logic [DAYS_W+15:0] prod;
  logic [15:0]        quot;
  logic [DAYS_W-1:0]  diff;
  logic [3:0]         r0;

  assign prod = {16'd0, x} * {{DAYS_W{1'b0}}, RECIP};
  assign quot = prod[DAYS_W +: 16];
  assign diff = x - DAYS_W'({quot, 3'b000} - {3'b000, quot});
  assign r0   = diff[3:0];

  always_comb begin
    if (r0 >= 4'd7) begin
      rem = WDAY_W'(r0 - 4'd7);
    end else begin
      rem = r0[WDAY_W-1:0];
    end
  end

  logic unused_diff;
  assign unused_diff = ^{diff[DAYS_W-1:4], prod[DAYS_W-1:0]};

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Bench for date_to_unix_seconds: random and edge-case dates, checked in order.
// ----------------------------------------------------------------------------
// A short directed list covers the field extremes, year and month clamping,
// day zero on the epoch, leap and century years and oversized hour, minute
// and second. Random dates follow, mostly in range with some full-width
// noise. The sender works in bursts with gaps and the receiver stalls on a
// rotating pattern. Every output transfer is compared field by field against
// a queue of predicted conversions.
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  import dtu_pkg::*;

  localparam int unsigned RANDOM_DATES = 1150;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned MAX_REPORTS  = 10;

  // cumulative days before each month, common year
  localparam int unsigned MONTH_START [12] = '{
    0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334
  };

  class date_scoreboard;
    out_t        pending_results[$];
    int unsigned mismatches;

    function out_t convert_date(in_t d);
      int unsigned yr;
      int unsigned mo;
      int unsigned mi;
      int unsigned ty;
      int unsigned ly;
      int unsigned yday;
      bit [63:0]   days;
      bit [63:0]   secs;
      bit          leap;
      out_t        r;
      yr = d.year;
      if (yr < 1970) yr = 1970;
      if (yr > 2399) yr = 2399;
      mo = d.month;
      if (mo < 1 || mo > 12) mo = 1;
      mi = mo - 1;
      ty = yr - 1900;
      // leap day of the current year only counts from March on
      ly = (mi <= 1) ? ty - 1 : ty;
      days = 64'(ty - 70) * 365 + 64'(MONTH_START[mi]);
      days = days + 64'((ly - 68) / 4) - 64'(ly / 100) + 64'((ly + 300) / 400);
      days = days + 64'(d.day);
      // days holds the day count plus one, so step back one day of seconds
      secs = days * 24 - 24 + 64'(d.hour);
      secs = secs * 60 + 64'(d.minute);
      secs = secs * 60 + 64'(d.second);
      leap = (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
      yday = MONTH_START[mi] + d.day + ((mo > 2 && leap) ? 1 : 0) - 1;
      r.epoch_seconds = secs[SECS_W-1:0];
      r.weekday       = WDAY_W'((days + 3) % 7);
      r.day_of_year   = yday[YDAY_W-1:0];
      return r;
    endfunction

    function void note_date(in_t d);
      pending_results.push_back(convert_date(d));
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: secs %0d wday %0d yday %0d",
                   got.epoch_seconds, got.weekday, got.day_of_year);
        return;
      end
      want = pending_results.pop_front();
      if (got.epoch_seconds !== want.epoch_seconds || got.weekday !== want.weekday ||
          got.day_of_year !== want.day_of_year) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("mismatch: exp secs %0d wday %0d yday %0d, got secs %0d wday %0d yday %0d",
                   want.epoch_seconds, want.weekday, want.day_of_year,
                   got.epoch_seconds, got.weekday, got.day_of_year);
      end
    endfunction
  endclass

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  date_scoreboard sb = new();
  in_t            dates[$];
  int unsigned    cycles = 0;

  date_to_unix_seconds u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // receiver: rotates between always ready, coin flip, heavy stall, periodic
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
    case ((cycles / 300) % 4)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(1));
      2: out_ready <= ($urandom_range(3) == 0);
      default: out_ready <= (cycles % 8 != 0);
    endcase
  end

  function in_t random_date();
    in_t d;
    int unsigned pick;
    logic [63:0] noise;
    pick = $urandom_range(19);
    if (pick < 3) begin
      // full-width noise, reaches clamping and oversized fields
      noise = {$urandom, $urandom};
      d = noise[$bits(in_t)-1:0];
    end else if (pick < 6) begin
      // around the end of February, mostly in century and leap years
      case ($urandom_range(5))
        0: d.year = 12'd2000;
        1: d.year = 12'd2100;
        2: d.year = 12'd2200;
        3: d.year = 12'd2300;
        4: d.year = 12'($urandom_range(492, 599) * 4);
        default: d.year = 12'($urandom_range(1970, 2399));
      endcase
      d.month  = 4'($urandom_range(2, 3));
      d.day    = 5'($urandom_range(1) ? $urandom_range(27, 31) : $urandom_range(0, 2));
      d.hour   = 5'($urandom_range(23));
      d.minute = 6'($urandom_range(59));
      d.second = 6'($urandom_range(59));
    end else begin
      d.year   = 12'($urandom_range(1970, 2399));
      d.month  = 4'($urandom_range(1, 12));
      d.day    = 5'($urandom_range(1, 31));
      d.hour   = 5'($urandom_range(23));
      d.minute = 6'($urandom_range(59));
      d.second = 6'($urandom_range(59));
    end
    return d;
  endfunction

  task automatic send_date(input in_t d);
    in_valid <= 1'b1;
    in_data  <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_date(d);
  endtask

  task automatic hold_off(input int unsigned n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  initial begin
    int unsigned burst;
    int unsigned sent;
    // year, month, day, hour, minute, second
    dates.push_back('{12'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0});
    dates.push_back('{12'd1970, 4'd1, 5'd0, 5'd0, 6'd0, 6'd0});
    dates.push_back('{12'd1970, 4'd1, 5'd0, 5'd23, 6'd59, 6'd59});
    dates.push_back('{12'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0});
    dates.push_back('{12'd4095, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63});
    dates.push_back('{12'd2399, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59});
    dates.push_back('{12'd2400, 4'd6, 5'd15, 5'd12, 6'd0, 6'd0});
    dates.push_back('{12'd1969, 4'd6, 5'd15, 5'd12, 6'd0, 6'd0});
    dates.push_back('{12'd2001, 4'd13, 5'd10, 5'd1, 6'd2, 6'd3});
    dates.push_back('{12'd2001, 4'd14, 5'd10, 5'd1, 6'd2, 6'd3});
    dates.push_back('{12'd2001, 4'd0, 5'd10, 5'd1, 6'd2, 6'd3});
    dates.push_back('{12'd2000, 4'd2, 5'd29, 5'd0, 6'd0, 6'd0});
    dates.push_back('{12'd2000, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0});
    dates.push_back('{12'd2100, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0});
    dates.push_back('{12'd2100, 4'd2, 5'd31, 5'd0, 6'd0, 6'd0});
    dates.push_back('{12'd1972, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59});
    dates.push_back('{12'd2038, 4'd1, 5'd19, 5'd3, 6'd14, 6'd8});
    dates.push_back('{12'd1999, 4'd7, 5'd4, 5'd31, 6'd0, 6'd0});
    dates.push_back('{12'd1999, 4'd7, 5'd4, 5'd0, 6'd63, 6'd0});
    dates.push_back('{12'd1999, 4'd7, 5'd4, 5'd0, 6'd0, 6'd63});
    dates.push_back('{12'd2300, 4'd11, 5'd0, 5'd10, 6'd20, 6'd30});
    for (int i = 0; i < RANDOM_DATES; i++) dates.push_back(random_date());

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    sent = 0;
    while (dates.size() != 0) begin
      burst = $urandom_range(1, 24);
      while (burst != 0 && dates.size() != 0) begin
        send_date(dates.pop_front());
        burst--;
        sent++;
      end
      // every third stretch of 250 transfers runs back to back
      if ((sent / 250) % 3 != 1 && $urandom_range(3) != 0)
        hold_off($urandom_range(1, 6));
    end
    in_valid <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
